@@ hw/rtl/fre_pkg.sv @@
package fre_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  // internal coordinate and decision widths
  localparam int CW = 20;
  localparam int DW = CW + 2;

  // command codes
  localparam logic [2:0] FUNC_PIXEL  = 3'd0;
  localparam logic [2:0] FUNC_LINE   = 3'd1;
  localparam logic [2:0] FUNC_CIRCLE = 3'd2;
  localparam logic [2:0] FUNC_FILLC  = 3'd3;
  localparam logic [2:0] FUNC_RECT   = 3'd4;
  localparam logic [2:0] FUNC_READ   = 3'd5;

  // drawing modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

endpackage

@@ hw/rtl/framebuffer_raster_engine_unit.sv @@
// Raster engine over a page-organized 1 bpp frame store. A command is taken
// when start is high and busy is low; busy then stays high until the single
// result beat (out_valid for one cycle, out_frame_byte zero unless a read)
// has been issued, and the receiver cannot stall it. One sequencer drives a
// read-modify-write port of the store: every pixel is read in S_PLOT_RD and,
// if it lands on screen, written back in S_PLOT_WR, and the shape walker
// passes through its own state for each line point, octant point, span pixel
// and span setup. After reset the store is cleared one byte per cycle, all
// STORE_DEPTH (1024) bytes, with busy high.
module framebuffer_raster_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic [1:0]          in_color,
  input  logic signed [15:0]  in_x_a,
  input  logic signed [15:0]  in_y_a,
  input  logic signed [15:0]  in_x_b,
  input  logic signed [15:0]  in_y_b,
  input  logic [14:0]         in_radius,
  input  logic signed [15:0]  in_span_w,
  input  logic signed [15:0]  in_span_h,
  input  logic [2:0]          in_page_index,
  input  logic [6:0]          in_column_index,
  output logic                out_valid,
  output logic [7:0]          out_frame_byte
);
  import fre_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PLOT_RD, S_PLOT_WR, S_LINE_CHK, S_CIR_OCT, S_CIR_STEP,
    S_FC_SPAN, S_FC_STEP, S_SPAN_INIT, S_SPAN_RUN, S_RECT_ROW, S_READ, S_DONE
  } state_t;

  localparam logic signed [CW-1:0] WMAX = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] HMAX = CW'(SCREEN_HEIGHT);

  state_t state_r, pret_r, sret_r;

  logic signed [CW-1:0] px_r, py_r;          // pixel being plotted
  logic [ADDR_W-1:0]    addr_r, clr_cnt_r;
  logic [2:0]           bit_r;
  logic [1:0]           mode_r;
  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r, dx_r, dy_r, err_r;
  logic                 stx_r, sty_r;
  logic signed [CW-1:0] cx_r, cy_r, cpx_r, cpy_r;
  logic signed [DW-1:0] d_r;
  logic [2:0]           oct_r;
  logic [1:0]           sp_r;
  logic                 first_r;
  logic signed [CW-1:0] sx_r, sy_r, sw_r, cur_r, hi_r;
  logic signed [CW-1:0] rx_r, rw_r, row_r, rhi_r;
  logic                 rd_ok_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;

  // frame store
  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // clipping and address of the current pixel
  logic              vis;
  logic [ADDR_W-1:0] pix_addr, rd_addr;
  logic              rd_ok;
  assign vis = (px_r >= 0) && (px_r < WMAX) && (py_r >= 0) && (py_r < HMAX);
  assign pix_addr = ADDR_W'(py_r[CW-1:3]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px_r);
  assign rd_addr = ADDR_W'(in_page_index) * ADDR_W'(SCREEN_WIDTH)
                 + ADDR_W'(in_column_index);
  assign rd_ok = (32'(in_page_index) < PAGE_COUNT)
              && (32'(in_column_index) < SCREEN_WIDTH);

  // modified byte for the write half
  logic [7:0] bmask, new_byte;
  always_comb begin
    bmask = 8'(1) << bit_r;
    case (mode_r)
      MODE_CLEAR:  new_byte = rdata_r & ~bmask;
      MODE_SET:    new_byte = rdata_r | bmask;
      MODE_INVERT: new_byte = rdata_r ^ bmask;
      default:     new_byte = rdata_r;
    endcase
  end

  // store port control
  always_comb begin
    mem_raddr = pix_addr;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = new_byte;
    if (state_r == S_IDLE) mem_raddr = rd_addr;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = 8'd0;
    end else if (state_r == S_PLOT_WR) begin
      mem_we = 1'b1;
    end
  end

  // line step
  logic signed [CW-1:0] e2, line_err, line_x, line_y;
  always_comb begin
    e2       = err_r <<< 1;
    line_err = err_r + ((e2 >= dy_r) ? dy_r : '0) + ((e2 <= dx_r) ? dx_r : '0);
    line_x   = x0_r;
    line_y   = y0_r;
    if (e2 >= dy_r) line_x = stx_r ? x0_r + 1 : x0_r - 1;
    if (e2 <= dx_r) line_y = sty_r ? y0_r + 1 : y0_r - 1;
  end

  // midpoint circle step
  logic signed [CW-1:0] st_px, st_py;
  logic signed [DW-1:0] st_d;
  always_comb begin
    st_px = cpx_r + 1;
    if (d_r < 0) begin
      st_d  = d_r + (DW'(cpx_r) <<< 1) + DW'(3);
      st_py = cpy_r;
    end else begin
      st_d  = d_r + (DW'(cpx_r - cpy_r) <<< 1) + DW'(5);
      st_py = cpy_r - 1;
    end
  end

  // octant point and filled-circle span
  logic signed [CW-1:0] oa, ob, ox, oy, sa, sb, fx, fy, fw;
  always_comb begin
    oa = oct_r[2] ? cpy_r : cpx_r;
    ob = oct_r[2] ? cpx_r : cpy_r;
    ox = oct_r[0] ? cx_r - oa : cx_r + oa;
    oy = oct_r[1] ? cy_r - ob : cy_r + ob;
    sa = sp_r[1] ? cpx_r : cpy_r;
    sb = sp_r[1] ? cpy_r : cpx_r;
    fx = cx_r - sa;
    fy = sp_r[0] ? cy_r - sb : cy_r + sb;
    fw = (sa <<< 1) + 1;
  end

  // span clip
  logic signed [CW-1:0] sp_end, sp_lo, sp_hi;
  logic signed [CW-1:0] r_end;
  always_comb begin
    sp_end = sx_r + sw_r;
    sp_lo  = (sx_r < 0) ? '0 : sx_r;
    sp_hi  = (sp_end > WMAX) ? WMAX : sp_end;
    r_end  = CW'(in_y_a) + CW'(in_span_h);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            mode_r  <= in_color;
            cx_r    <= CW'(in_x_a);
            cy_r    <= CW'(in_y_a);
            cpx_r   <= '0;
            cpy_r   <= CW'(in_radius);
            d_r     <= DW'(1) - DW'(in_radius);
            oct_r   <= '0;
            sp_r    <= '0;
            first_r <= 1'b1;
            rd_ok_r <= rd_ok;
            case (in_func)
              FUNC_PIXEL: begin
                px_r    <= CW'(in_x_a);
                py_r    <= CW'(in_y_a);
                pret_r  <= S_DONE;
                state_r <= S_PLOT_RD;
              end
              FUNC_LINE: begin
                x0_r    <= CW'(in_x_a);
                y0_r    <= CW'(in_y_a);
                x1_r    <= CW'(in_x_b);
                y1_r    <= CW'(in_y_b);
                px_r    <= CW'(in_x_a);
                py_r    <= CW'(in_y_a);
                dx_r    <= (in_x_b > in_x_a) ? CW'(in_x_b) - CW'(in_x_a)
                                             : CW'(in_x_a) - CW'(in_x_b);
                dy_r    <= (in_y_b > in_y_a) ? CW'(in_y_a) - CW'(in_y_b)
                                             : CW'(in_y_b) - CW'(in_y_a);
                err_r   <= ((in_x_b > in_x_a) ? CW'(in_x_b) - CW'(in_x_a)
                                              : CW'(in_x_a) - CW'(in_x_b))
                         + ((in_y_b > in_y_a) ? CW'(in_y_a) - CW'(in_y_b)
                                              : CW'(in_y_b) - CW'(in_y_a));
                stx_r   <= in_x_a < in_x_b;
                sty_r   <= in_y_a < in_y_b;
                pret_r  <= S_LINE_CHK;
                state_r <= S_PLOT_RD;
              end
              FUNC_CIRCLE: state_r <= S_CIR_OCT;
              FUNC_FILLC:  state_r <= S_FC_SPAN;
              FUNC_RECT: begin
                rx_r  <= CW'(in_x_a);
                rw_r  <= CW'(in_span_w);
                row_r <= (in_y_a < 0) ? '0 : CW'(in_y_a);
                rhi_r <= (r_end > HMAX) ? HMAX : r_end;
                if (in_span_w <= 0 || in_span_h <= 0) state_r <= S_DONE;
                else state_r <= S_RECT_ROW;
              end
              FUNC_READ: state_r <= S_READ;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_PLOT_RD: begin
          addr_r <= pix_addr;
          bit_r  <= py_r[2:0];
          state_r <= vis ? S_PLOT_WR : pret_r;
        end
        S_PLOT_WR: state_r <= pret_r;
        S_LINE_CHK: begin
          if (x0_r == x1_r && y0_r == y1_r) begin
            state_r <= S_DONE;
          end else begin
            err_r   <= line_err;
            x0_r    <= line_x;
            y0_r    <= line_y;
            px_r    <= line_x;
            py_r    <= line_y;
            state_r <= S_PLOT_RD;
          end
        end
        S_CIR_OCT: begin
          px_r    <= ox;
          py_r    <= oy;
          oct_r   <= oct_r + 1'b1;
          pret_r  <= (oct_r == 3'd7) ? S_CIR_STEP : S_CIR_OCT;
          state_r <= S_PLOT_RD;
        end
        S_CIR_STEP: begin
          if (cpx_r < cpy_r) begin
            cpx_r   <= st_px;
            cpy_r   <= st_py;
            d_r     <= st_d;
            oct_r   <= '0;
            state_r <= S_CIR_OCT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_FC_SPAN: begin
          sx_r    <= fx;
          sy_r    <= fy;
          sw_r    <= fw;
          sret_r  <= (first_r || sp_r == 2'd3) ? S_FC_STEP : S_FC_SPAN;
          sp_r    <= first_r ? 2'd0 : sp_r + 1'b1;
          first_r <= 1'b0;
          state_r <= S_SPAN_INIT;
        end
        S_FC_STEP: begin
          if (cpx_r < cpy_r) begin
            cpx_r   <= st_px;
            cpy_r   <= st_py;
            d_r     <= st_d;
            sp_r    <= '0;
            state_r <= S_FC_SPAN;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SPAN_INIT: begin
          cur_r <= sp_lo;
          hi_r  <= sp_hi;
          if (sw_r <= 0 || sy_r < 0 || sy_r >= HMAX) state_r <= sret_r;
          else state_r <= S_SPAN_RUN;
        end
        S_SPAN_RUN: begin
          if (cur_r < hi_r) begin
            px_r    <= cur_r;
            py_r    <= sy_r;
            cur_r   <= cur_r + 1;
            pret_r  <= S_SPAN_RUN;
            state_r <= S_PLOT_RD;
          end else begin
            state_r <= sret_r;
          end
        end
        S_RECT_ROW: begin
          if (row_r < rhi_r) begin
            sx_r    <= rx_r;
            sy_r    <= row_r;
            sw_r    <= rw_r;
            row_r   <= row_r + 1;
            sret_r  <= S_RECT_ROW;
            state_r <= S_SPAN_INIT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_byte_r  <= rd_ok_r ? rdata_r : 8'd0;
          state_r     <= S_IDLE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_byte_r  <= 8'd0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;

endmodule
